FILE: sv/imh_pkg.sv
// imh_pkg: shared types, constants and opcodes for the indexed min-heap set
// no dependencies
`timescale 1ns / 1ps

package imh_pkg;

    localparam int VAL_W = 10;
    localparam int CNT_W = 11;
    localparam int NUM_VALUES = 1024;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SAME = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [VAL_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [VAL_W-1:0] min_value;
        logic [CNT_W-1:0] count;
    } out_word_t;

endpackage

FILE: sv/imh_ram.sv
// imh_ram: generic single-port-write, single-read RAM with registered read
// no dependencies
`timescale 1ns / 1ps

module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/indexed_min_heap_set.sv
// indexed_min_heap_set: indexed binary min-heap over element numbers 0..1023
// depends on imh_pkg and imh_ram
//
//   channel | valid     | stall     | word
//   in      | in_valid  | in_stall  | in_word  (op, value)
//   out     | out_valid | out_stall | out_word (status, min_value, count)
//
// each word runs through a sequencer over the heap and position memories;
// a sift-up level reads the parent, then compares and moves; a sift-down
// level reads the left child, then the right child, then compares and moves
// after reset a clearing pass zeroes the position memory;
// clear runs the same pass; no word is taken during it
// a finished word waits in the output register; in_stall is high while busy
`timescale 1ns / 1ps

module indexed_min_heap_set
    import imh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_RDH   = 4'd4;
    localparam logic [3:0] S_RDP   = 4'd5;
    localparam logic [3:0] S_UPC   = 4'd6;
    localparam logic [3:0] S_DNA   = 4'd7;
    localparam logic [3:0] S_DNB   = 4'd8;
    localparam logic [3:0] S_DNC   = 4'd9;
    localparam logic [3:0] S_PUT   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_RDL   = 4'd12;
    localparam logic [3:0] S_RDLW  = 4'd13;
    localparam logic [3:0] S_RDPW  = 4'd14;

    // memories: heap slot 0 unused, slots addressed 1..1023 plus 1024 mapped
    // through an 11-bit slot whose top bit only appears at count 1024
    logic            h_we;
    logic [CNT_W-1:0] h_waddr, h_raddr;
    logic [VAL_W-1:0] h_wdata, h_rdata;
    logic            p_we;
    logic [VAL_W-1:0] p_waddr, p_raddr;
    logic [CNT_W-1:0] p_wdata, p_rdata;

    imh_ram #(.WIDTH(VAL_W), .DEPTH(2 * NUM_VALUES)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    imh_ram #(.WIDTH(CNT_W), .DEPTH(NUM_VALUES)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] child_reg, child_next;
    logic [VAL_W-1:0] v_reg, v_next;
    logic [VAL_W-1:0] cv_reg, cv_next;
    logic [VAL_W-1:0] clr_reg, clr_next;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       st_reg, st_next;
    logic [VAL_W-1:0] mv_reg, mv_next;
    logic             ov_reg, ov_next;
    out_word_t        ow_reg, ow_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            op_reg    <= OP_ADD;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        child_reg <= child_next;
        v_reg     <= v_next;
        cv_reg    <= cv_next;
        st_reg    <= st_next;
        mv_reg    <= mv_next;
        ow_reg    <= ow_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        child_next = child_reg;
        v_next     = v_reg;
        cv_next    = cv_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        mv_next    = mv_reg;
        ov_next    = ov_reg;
        ow_next    = ow_reg;
        h_we = 1'b0; h_waddr = slot_reg; h_wdata = v_reg; h_raddr = slot_reg;
        p_we = 1'b0; p_waddr = v_reg; p_wdata = slot_reg; p_raddr = v_reg;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                p_we = 1'b1; p_waddr = clr_reg; p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == VAL_W'(NUM_VALUES - 1))
                begin
                    state_next = (op_reg == OP_CLEAR) ? S_OUT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                op_next = in_word.op;
                v_next  = in_word.value;
                p_raddr = in_word.value;
                st_next = ST_DONE;
                mv_next = '0;
                if (in_valid)
                begin
                    unique case (in_word.op)
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                            clr_next = '0;
                            state_next = S_CLR;
                        end
                        OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next = ST_EMPTY;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                slot_next = CNT_W'(1);
                                h_raddr = CNT_W'(1);
                                state_next = S_RDH;
                            end
                        end
                        default:
                        begin
                            state_next = S_POS;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                // position of value is on p_rdata
                if (op_reg == OP_ADD)
                begin
                    if (p_rdata != '0)
                    begin
                        st_next = ST_SAME;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        slot_next = cnt_reg + 1'b1;
                        state_next = S_UPC;
                        h_raddr = (cnt_reg + 1'b1) >> 1;
                    end
                end
                else if (p_rdata == '0 || p_rdata > cnt_reg)
                begin
                    st_next = ST_SAME;
                    state_next = S_OUT;
                end
                else
                begin
                    slot_next = p_rdata;
                    h_raddr = p_rdata;
                    state_next = S_RDH;
                end
            end
            S_RDH:
            begin
                // removed element at h_rdata; clear its position
                if (op_reg == OP_POP)
                begin
                    mv_next = h_rdata;
                end
                p_we = 1'b1; p_waddr = h_rdata; p_wdata = '0;
                cnt_next = cnt_reg - 1'b1;
                if (slot_reg == cnt_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    h_raddr = cnt_reg;
                    state_next = S_RDL;
                end
            end
            S_RDL:
            begin
                v_next = h_rdata;
                h_raddr = slot_reg >> 1;
                state_next = (slot_reg > CNT_W'(1)) ? S_RDPW : S_DNA;
            end
            S_RDPW:
            begin
                // parent value of hole on h_rdata
                if (v_reg < h_rdata)
                begin
                    h_raddr = slot_reg >> 1;
                    state_next = S_RDLW;
                end
                else
                begin
                    state_next = S_DNA;
                end
            end
            S_RDLW:
            begin
                h_raddr = slot_reg >> 1;
                state_next = S_UPC;
            end
            S_UPC:
            begin
                // parent of slot on h_rdata when slot > 1
                if (slot_reg > CNT_W'(1) && v_reg < h_rdata)
                begin
                    h_we = 1'b1; h_waddr = slot_reg; h_wdata = h_rdata;
                    p_we = 1'b1; p_waddr = h_rdata; p_wdata = slot_reg;
                    slot_next = slot_reg >> 1;
                    state_next = S_RDP;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_RDP:
            begin
                h_raddr = slot_reg >> 1;
                state_next = S_UPC;
            end
            S_DNA:
            begin
                child_next = {slot_reg[CNT_W-2:0], 1'b0};
                h_raddr = {slot_reg[CNT_W-2:0], 1'b0};
                if (slot_reg[CNT_W-1] || {slot_reg[CNT_W-2:0], 1'b0} > cnt_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_DNB;
                end
            end
            S_DNB:
            begin
                cv_next = h_rdata;
                h_raddr = child_reg + 1'b1;
                state_next = S_DNC;
            end
            S_DNC:
            begin
                if (child_reg + 1'b1 <= cnt_reg && h_rdata < cv_reg)
                begin
                    if (h_rdata < v_reg)
                    begin
                        h_we = 1'b1; h_waddr = slot_reg; h_wdata = h_rdata;
                        p_we = 1'b1; p_waddr = h_rdata; p_wdata = slot_reg;
                        slot_next = child_reg + 1'b1;
                        state_next = S_DNA;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
                else if (cv_reg < v_reg)
                begin
                    h_we = 1'b1; h_waddr = slot_reg; h_wdata = cv_reg;
                    p_we = 1'b1; p_waddr = cv_reg; p_wdata = slot_reg;
                    slot_next = child_reg;
                    state_next = S_DNA;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                h_we = 1'b1; h_waddr = slot_reg; h_wdata = v_reg;
                p_we = 1'b1; p_waddr = v_reg; p_wdata = slot_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    ow_next.status = st_reg;
                    ow_next.min_value = mv_reg;
                    ow_next.count = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: verif/imh_checker.sv
// imh_checker: watches both channels of the indexed min-heap set, predicts each result
// depends on imh_pkg; instantiated by tb beside the block
`timescale 1ns / 1ps

module imh_checker
    import imh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_word_t  in_word,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_word_t out_word,
    output int        fail_count,
    output int        pending,
    output int        result_total,
    output int        pop_total
);

    // predicted heap contents, 1-based slots
    logic [VAL_W-1:0] heap_q [1:NUM_VALUES];
    logic [CNT_W-1:0] slot_of [0:NUM_VALUES-1];
    logic [CNT_W-1:0] held;
    out_word_t        result_q [$];

    function automatic void place(int slot, logic [VAL_W-1:0] v);
        heap_q[slot] = v;
        slot_of[v] = CNT_W'(slot);
    endfunction

    function automatic void bubble_up(logic [VAL_W-1:0] v, int slot);
        int parent;
        while (slot > 1)
        begin
            parent = slot / 2;
            if (!(v < heap_q[parent]))
                break;
            place(slot, heap_q[parent]);
            slot = parent;
        end
        place(slot, v);
    endfunction

    function automatic void bubble_down(logic [VAL_W-1:0] v, int slot);
        int child;
        while (1)
        begin
            child = slot * 2;
            if (child > held)
                break;
            if (child + 1 <= held && heap_q[child + 1] < heap_q[child])
                child++;
            if (!(heap_q[child] < v))
                break;
            place(slot, heap_q[child]);
            slot = child;
        end
        place(slot, v);
    endfunction

    function automatic void take_slot(int slot);
        int n;
        logic [VAL_W-1:0] last;
        n = held;
        slot_of[heap_q[slot]] = '0;
        held = CNT_W'(n - 1);
        if (slot != n)
        begin
            last = heap_q[n];
            if (slot > 1 && last < heap_q[slot / 2])
                bubble_up(last, slot);
            else
                bubble_down(last, slot);
        end
    endfunction

    // apply one operation and return the expected result word
    function automatic out_word_t heap_apply(in_word_t w);
        out_word_t r;
        r = '0;
        r.status = ST_DONE;
        case (w.op)
            OP_ADD:
                if (int'(w.value) >= NUM_VALUES)
                    r.status = ST_RANGE;
                else if (slot_of[w.value] != 0 || held >= NUM_VALUES)
                    r.status = ST_SAME;
                else
                begin
                    held++;
                    bubble_up(w.value, held);
                end
            OP_REMOVE:
                if (int'(w.value) >= NUM_VALUES)
                    r.status = ST_RANGE;
                else if (slot_of[w.value] == 0 || slot_of[w.value] > held)
                    r.status = ST_SAME;
                else
                    take_slot(slot_of[w.value]);
            OP_POP:
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.min_value = heap_q[1];
                    take_slot(1);
                end
            default:
            begin
                for (int i = 0; i < NUM_VALUES; i++)
                    slot_of[i] = '0;
                held = '0;
            end
        endcase
        r.count = held;
        return r;
    endfunction

    assign pending = result_q.size();

    // predict on each accepted input word, compare each accepted output word
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VALUES; i++)
                slot_of[i] = '0;
            held = '0;
            result_q.delete();
            fail_count <= 0;
            result_total <= 0;
            pop_total <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                result_q.push_back(heap_apply(in_word));
                if (in_word.op == OP_POP)
                    pop_total <= pop_total + 1;
            end
            if (out_valid && !out_stall)
            begin
                result_total <= result_total + 1;
                if (result_q.size() == 0)
                begin
                    $error("unexpected result word %h", out_word);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (e.status != out_word.status)
                        $error("status: expected %0d, got %0d", e.status, out_word.status);
                    if (e.min_value != out_word.min_value)
                        $error("min_value: expected %0d, got %0d",
                            e.min_value, out_word.min_value);
                    if (e.count != out_word.count)
                        $error("count: expected %0d, got %0d", e.count, out_word.count);
                    if (e != out_word)
                        fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for indexed_min_heap_set
// depends on imh_pkg, indexed_min_heap_set and imh_checker
`timescale 1ns / 1ps

module tb;
    import imh_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;
    int        fail_count;
    int        pending;
    int        result_total;
    int        pop_total;
    int        cycle_count = 0;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        present [$];

    indexed_min_heap_set dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    imh_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .fail_count(fail_count), .pending(pending),
        .result_total(result_total), .pop_total(pop_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** indexed_min_heap_set: FAILED **");
            $finish;
        end
    end

    // receiver stalls at random
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // offer one word, hold it until accepted
    task automatic send_word(logic [1:0] op, logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_word <= '{op: op, value: v};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // random operation, mostly adds of random values and removals of held ones, to reach deep sifts
    task automatic random_op();
        int k;
        int sel;
        logic [VAL_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 50)
        begin
            v = VAL_W'($urandom);
            send_word(OP_ADD, v);
            present.push_back(int'(v));
        end
        else if (sel < 72 && present.size() > 0)
        begin
            k = $urandom_range(present.size() - 1);
            send_word(OP_REMOVE, VAL_W'(present[k]));
            present.delete(k);
        end
        else if (sel < 80)
            send_word(OP_REMOVE, VAL_W'($urandom));
        else if (sel < 99)
            send_word(OP_POP, VAL_W'($urandom));
        else
        begin
            send_word(OP_CLEAR, VAL_W'($urandom));
            present.delete();
        end
    endtask

    initial
    begin
        int idle_mode [4][2];
        idle_mode = '{'{0, 0}, '{86, 0}, '{0, 86}, '{16, 16}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, extremes, duplicates, absent removal, clear
        send_word(OP_POP, 10'h3ff);
        send_word(OP_REMOVE, 10'd0);
        send_word(OP_ADD, 10'h3ff);
        send_word(OP_ADD, 10'd0);
        send_word(OP_ADD, 10'h3ff);
        send_word(OP_ADD, 10'h2aa);
        send_word(OP_ADD, 10'h155);
        send_word(OP_ADD, 10'd1);
        send_word(OP_REMOVE, 10'd0);
        send_word(OP_REMOVE, 10'd0);
        send_word(OP_REMOVE, 10'h155);
        send_word(OP_POP, 10'd0);
        send_word(OP_ADD, 10'd7);
        send_word(OP_ADD, 10'd3);
        send_word(OP_ADD, 10'd9);
        send_word(OP_ADD, 10'd2);
        send_word(OP_REMOVE, 10'd7);
        send_word(OP_POP, 10'd0);
        send_word(OP_CLEAR, 10'h3ff);
        send_word(OP_POP, 10'd0);
        send_word(OP_REMOVE, 10'd9);
        send_word(OP_ADD, 10'd9);
        send_word(OP_CLEAR, 10'd0);

        // random phases under each idling mode
        for (int ph = 0; ph < 5; ph++)
        begin
            send_idle_pct = idle_mode[ph % 4][0];
            recv_stall_pct = idle_mode[ph % 4][1];
            for (int i = 0; i < 325; i++)
                random_op();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("ran %0d result words, %0d pop operations, over four idling modes",
            result_total, pop_total);
        if (fail_count == 0 && pending == 0)
            $display("** indexed_min_heap_set: PASSED **");
        else
            $display("** indexed_min_heap_set: FAILED **");
        $finish;
    end

endmodule
